@@ hdl/rqvg_pkg.sv @@
// ----------------------------------------------------------------------------
// rqvg_pkg
// Shared types, constants and the arctangent table of the sprite quad engine.
// ----------------------------------------------------------------------------
package rqvg_pkg;

	localparam int CORDIC_W = 34;
	localparam int DIV_W    = 9;
	localparam int QUO_BITS = 16;
	localparam int LANES    = 4;

	localparam logic signed [CORDIC_W-1:0] CORDIC_ONE_K = 34'sd652032874;
	localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic [1:0] CORNER_LAST = 2'd3;
	localparam logic [15:0] TEX_MAX = 16'hFFFF;

	// lanes 0/1 are u start/end, lanes 2/3 are v start/end
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		logic                       flip;
		logic [LANES-1:0][DIV_W-1:0]    rem;
		logic [LANES-1:0][QUO_BITS-1:0] num;
		logic [LANES-1:0][QUO_BITS-1:0] quo;
		logic [LANES-1:0]               sat;
		logic [DIV_W-1:0]               du;
		logic [DIV_W-1:0]               dv;
	} cell_t;

	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
			15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
			21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/rqvg_cell.sv @@
// ----------------------------------------------------------------------------
// rqvg_cell
// One cell of the chain: a rotation step and/or a quotient bit for each lane.
// ----------------------------------------------------------------------------
module rqvg_cell import rqvg_pkg::*; #(
	parameter int STAGE        = 0,
	parameter int ANGLE_STAGES = 16,
	parameter int SIDE_W       = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  cell_t             in_d,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output cell_t             out_d,
	output logic [SIDE_W-1:0] out_side
);

	cell_t nxt;
	logic signed [CORDIC_W-1:0] dx, dy, at;
	logic [DIV_W-1:0] dsr;
	logic [DIV_W:0]   trial;

	always_comb begin
		nxt   = in_d;
		dx    = in_d.y >>> STAGE;
		dy    = in_d.x >>> STAGE;
		at    = signed'({2'b00, atan_turn(STAGE)});
		dsr   = '0;
		trial = '0;
		if (STAGE < ANGLE_STAGES) begin
			if (!in_d.z[CORDIC_W-1]) begin
				nxt.x = in_d.x - dx;
				nxt.y = in_d.y + dy;
				nxt.z = in_d.z - at;
			end else begin
				nxt.x = in_d.x + dx;
				nxt.y = in_d.y - dy;
				nxt.z = in_d.z + at;
			end
		end
		if (STAGE < QUO_BITS) begin
			for (int l = 0; l < LANES; l++) begin
				dsr   = (l < 2) ? in_d.du : in_d.dv;
				trial = {in_d.rem[l], in_d.num[l][QUO_BITS-1]};
				if (trial >= {1'b0, dsr}) begin
					nxt.rem[l] = DIV_W'(trial - {1'b0, dsr});
					nxt.quo[l] = {in_d.quo[l][QUO_BITS-2:0], 1'b1};
				end else begin
					nxt.rem[l] = trial[DIV_W-1:0];
					nxt.quo[l] = {in_d.quo[l][QUO_BITS-2:0], 1'b0};
				end
				nxt.num[l] = {in_d.num[l][QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d    <= nxt;
			out_side <= in_side;
		end
	end

endmodule

@@ hdl/rqvg_corner.sv @@
// ----------------------------------------------------------------------------
// rqvg_corner
// Products of sine/cosine and size, then four corner words per sprite.
// ----------------------------------------------------------------------------
module rqvg_corner import rqvg_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int OUT_W      = 96
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  cell_t                   in_d,
	input  logic [2*COORD_BITS+63:0] in_side,
	output logic                    adv,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_W-1:0]        m_tdata,
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);

	localparam int PW = 49;
	localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 35;
	localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	localparam logic signed [SW-1:0] RND = SW'(64'sd1 <<< 30);

	logic signed [COORD_BITS-1:0] cx, cy;
	logic signed [16:0] w17, h17;
	logic signed [31:0] s32, c32;
	logic [LANES-1:0][15:0] tex;

	logic               prod_v_s1;
	logic signed [PW-1:0] sh_s1, ch_s1, sw_s1, cw_s1;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1;
	logic               flip_s1;
	logic [LANES-1:0][15:0] tex_s1;
	logic [31:0]        col_s1;

	logic               ser_v_q;
	logic [1:0]         corner_q;
	logic signed [PW-1:0] sh_q, ch_q, sw_q, cw_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic               flip_q;
	logic [LANES-1:0][15:0] tex_q;
	logic [31:0]        col_q;

	logic ser_take, out_load, right, bottom;
	logic signed [SW-1:0] tx, ty, rx, ry;
	logic signed [COORD_BITS-1:0] ox, oy;

	logic                    out_v_q;
	logic [OUT_W-1:0]        data_q;
	logic [1:0]              user_q;
	logic                    last_q;

	assign cx  = in_side[COORD_BITS-1:0];
	assign cy  = in_side[2*COORD_BITS-1:COORD_BITS];
	assign w17 = signed'({1'b0, in_side[2*COORD_BITS+15:2*COORD_BITS]});
	assign h17 = signed'({1'b0, in_side[2*COORD_BITS+31:2*COORD_BITS+16]});
	assign s32 = in_d.y[31:0];
	assign c32 = in_d.x[31:0];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			tex[l] = in_d.sat[l] ? TEX_MAX : in_d.quo[l];
		end
	end

	assign out_load = ser_v_q && (!out_v_q || m_tready);
	assign ser_take = prod_v_s1 && (!ser_v_q || (out_load && corner_q == CORNER_LAST));
	assign adv      = !prod_v_s1 || ser_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else if (adv) begin
			prod_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_s1   <= PW'(s32 * h17);
			ch_s1   <= PW'(c32 * h17);
			sw_s1   <= PW'(s32 * w17);
			cw_s1   <= PW'(c32 * w17);
			cx_s1   <= cx;
			cy_s1   <= cy;
			flip_s1 <= in_d.flip;
			tex_s1  <= tex;
			col_s1  <= in_side[2*COORD_BITS+63:2*COORD_BITS+32];
		end
	end

	// serializer: hold one sprite, step through its corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q  <= 1'b0;
			corner_q <= '0;
		end else begin
			if (out_load) begin
				corner_q <= corner_q + 2'd1;
				if (corner_q == CORNER_LAST) begin
					ser_v_q <= 1'b0;
				end
			end
			if (ser_take) begin
				ser_v_q  <= 1'b1;
				corner_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take) begin
			sh_q   <= sh_s1;
			ch_q   <= ch_s1;
			sw_q   <= sw_s1;
			cw_q   <= cw_s1;
			cx_q   <= cx_s1;
			cy_q   <= cy_s1;
			flip_q <= flip_s1;
			tex_q  <= tex_s1;
			col_q  <= col_s1;
		end
	end

	// a half-turn fold negates sine and cosine, so it flips every term sign
	always_comb begin
		right  = corner_q[0];
		bottom = corner_q[1];
		tx = (SW'(cx_q) <<< 31)
			+ (((bottom != flip_q)) ? SW'(sh_q) : -SW'(sh_q))
			+ (((right  != flip_q)) ? SW'(cw_q) : -SW'(cw_q));
		ty = (SW'(cy_q) <<< 31)
			+ (((bottom != flip_q)) ? SW'(ch_q) : -SW'(ch_q))
			+ (((!right != flip_q)) ? SW'(sw_q) : -SW'(sw_q));
		rx = (tx + RND) >>> 31;
		ry = (ty + RND) >>> 31;
		ox = (rx > HI) ? HI[COORD_BITS-1:0] : (rx < LO) ? LO[COORD_BITS-1:0] : rx[COORD_BITS-1:0];
		oy = (ry > HI) ? HI[COORD_BITS-1:0] : (ry < LO) ? LO[COORD_BITS-1:0] : ry[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			data_q <= OUT_W'({col_q, tex_q[bottom ? 3 : 2], tex_q[right ? 1 : 0], oy, ox});
			user_q <= corner_q;
			last_q <= (corner_q == CORNER_LAST);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

@@ hdl/rotated_quad_vertex_generator_unit.sv @@
// Path: NCELL cells (max(ANGLE_STAGES,16)), then the product, serializer and output registers.
// The corner serializer emits 4 words per sprite, taking the next when empty or as its last word is loaded.
// The cell chain accepts a word every cycle while the serializer keeps up.
// Reset: arst_n clears all valid bits and the corner counter; payload is not reset.
// ----------------------------------------------------------------------------
// rotated_quad_vertex_generator_unit
// Sprite to four rotated, textured triangle-strip corners.
// ----------------------------------------------------------------------------
module rotated_quad_vertex_generator_unit import rqvg_pkg::*; #(
	parameter int COORD_BITS   = 16,
	parameter int ANGLE_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// centre_x, centre_y, rotation, width, height, pattern_u, pattern_v,
	// divisions_u, divisions_v, colour, zero pad
	input  logic [((2*COORD_BITS+114+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// corner_x, corner_y, tex_u, tex_v, vertex_colour, zero pad
	output logic [((2*COORD_BITS+64+7)/8)*8-1:0] m_tdata,
	// corner_index
	output logic [1:0] m_tuser,
	output logic m_tlast
);

	localparam int B      = 2*COORD_BITS;
	localparam int NCELL  = (ANGLE_STAGES > QUO_BITS) ? ANGLE_STAGES : QUO_BITS;
	localparam int SIDE_W = 2*COORD_BITS + 64;
	localparam int OUT_W  = ((2*COORD_BITS+64+7)/8)*8;

	cell_t pre;
	logic signed [CORDIC_W-1:0] z0;
	logic [DIV_W-1:0] du, dv;
	logic [LANES-1:0][8:0] nn;
	logic [LANES-1:0][23:0] num;
	logic [SIDE_W-1:0] side0;
	logic adv;

	cell_t             d_c [NCELL+1];
	logic [SIDE_W-1:0] s_c [NCELL+1];
	logic              v_c [NCELL+1];

	always_comb begin
		du = s_tdata[B+72:B+64];
		dv = s_tdata[B+81:B+73];
		if (du == '0) du = DIV_W'(1);
		if (dv == '0) dv = DIV_W'(1);
		nn[0] = {1'b0, s_tdata[B+55:B+48]};
		nn[1] = 9'({1'b0, s_tdata[B+55:B+48]} + 9'd1);
		nn[2] = {1'b0, s_tdata[B+63:B+56]};
		nn[3] = 9'({1'b0, s_tdata[B+63:B+56]} + 9'd1);
		pre = '0;
		z0 = CORDIC_W'(signed'({s_tdata[B+15:B], 16'h0000}));
		pre.x = CORDIC_ONE_K;
		pre.z = z0;
		if (z0 > QUARTER_TURN) begin
			pre.z = z0 - HALF_TURN;
			pre.flip = 1'b1;
		end else if (z0 < -QUARTER_TURN) begin
			pre.z = z0 + HALF_TURN;
			pre.flip = 1'b1;
		end
		pre.du = du;
		pre.dv = dv;
		for (int l = 0; l < LANES; l++) begin
			num[l] = {nn[l], 15'h0000} + 24'((l < 2) ? (du >> 1) : (dv >> 1));
			pre.rem[l] = {1'b0, num[l][23:16]};
			pre.num[l] = num[l][15:0];
			// quotient needs more than 16 bits: clamp
			pre.sat[l] = ({1'b0, num[l][23:16]} >= ((l < 2) ? du : dv));
		end
		side0 = {s_tdata[B+113:B+82], s_tdata[B+47:B+16], s_tdata[B-1:0]};
	end

	assign d_c[0]   = pre;
	assign s_c[0]   = side0;
	assign v_c[0]   = s_tvalid;
	assign s_tready = adv;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		rqvg_cell #(
			.STAGE(g), .ANGLE_STAGES(ANGLE_STAGES), .SIDE_W(SIDE_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.in_valid(v_c[g]), .in_d(d_c[g]), .in_side(s_c[g]),
			.out_valid(v_c[g+1]), .out_d(d_c[g+1]), .out_side(s_c[g+1])
		);
	end

	rqvg_corner #(.COORD_BITS(COORD_BITS), .OUT_W(OUT_W)) u_corner (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_c[NCELL]), .in_d(d_c[NCELL]), .in_side(s_c[NCELL]),
		.adv(adv),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

@@ hdl/rqvg_checker.sv @@
// ----------------------------------------------------------------------------
// rqvg_checker
// Port-level checks on the corner word stream.
// ----------------------------------------------------------------------------
module rqvg_checker #(
	parameter int OUT_W = 96
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser,
	input logic             m_tlast
);

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
		else $error("tlast does not match fourth corner");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled word changed");

	a_corner_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == 2'($past(m_tuser) + 2'd1))
		else $error("corner sequence broken");

	a_first_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tuser == 2'd0)
		else $error("sprite does not start at top-left");

endmodule

bind rotated_quad_vertex_generator_unit rqvg_checker #(.OUT_W(OUT_W)) u_rqvg_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ sim/rotated_quad_vertex_generator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_quad_vertex_generator_unit_test
// Drives sprite words into the quad engine and checks each corner word against
// a local sine/cosine and texture predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module rotated_quad_vertex_generator_unit_test;
	import rqvg_pkg::*;

	localparam int CB = 16;
	localparam int IN_W = ((2*CB+114+7)/8)*8;
	localparam int OUT_W = ((2*CB+64+7)/8)*8;
	localparam int N_RANDOM = 350;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [31:0] colour;
		logic [8:0]  div_v;
		logic [8:0]  div_u;
		logic [7:0]  pat_v;
		logic [7:0]  pat_u;
		logic [15:0] height;
		logic [15:0] width;
		logic [15:0] rotation;
		logic [CB-1:0] cy;
		logic [CB-1:0] cx;
	} sprite_t;

	localparam int SP_W = $bits(sprite_t);

	typedef struct packed {
		logic [1:0]  index;
		logic        last;
		logic [31:0] colour;
		logic [15:0] v;
		logic [15:0] u;
		logic [CB-1:0] y;
		logic [CB-1:0] x;
	} corner_t;

	typedef struct {
		sprite_t sp;
		logic    has_exp;
		corner_t c0;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	rotated_quad_vertex_generator_unit #(.COORD_BITS(CB), .ANGLE_STAGES(16)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	corner_t pending_corners[$];
	int errors = 0;
	int cycles = 0;
	bit quiet_phase = 0;
	bit send_done = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint floor_shift(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic void rotate_sincos(input logic [15:0] rot, output longint sn, output longint cs);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(rot) << 16;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z >= 64'sd2147483648) z -= 64'sd4294967296;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		sn = y;
		cs = x;
	endfunction

	function automatic logic [CB-1:0] round_sat(input longint sum);
		longint v;
		v = (sum + (64'sd1 << 30)) >>> 31;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[CB-1:0];
	endfunction

	function automatic logic [15:0] tex_frac(input longint n, input logic [8:0] d);
		longint dd, q;
		dd = (d == 0) ? 1 : longint'(d);
		q = (n * 32768 + dd / 2) / dd;
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic void predict_corners(input sprite_t sp, output corner_t q[4]);
		longint s, c, sh, ch, sw, cw, px, py, xs, ys;
		bit r, b;
		rotate_sincos(sp.rotation, s, c);
		sh = s * longint'(sp.height);
		ch = c * longint'(sp.height);
		sw = s * longint'(sp.width);
		cw = c * longint'(sp.width);
		px = longint'($signed(sp.cx)) * 64'sd2147483648;
		py = longint'($signed(sp.cy)) * 64'sd2147483648;
		for (int k = 0; k < 4; k++) begin
			r = k[0];
			b = k[1];
			xs = px + (b ? sh : -sh) + (r ? cw : -cw);
			ys = py + (b ? ch : -ch) - (r ? sw : -sw);
			q[k].index = k[1:0];
			q[k].x = round_sat(xs);
			q[k].y = round_sat(ys);
			q[k].u = tex_frac(longint'(sp.pat_u) + (r ? 1 : 0), sp.div_u);
			q[k].v = tex_frac(longint'(sp.pat_v) + (b ? 1 : 0), sp.div_v);
			q[k].colour = sp.colour;
			q[k].last = (k[1:0] == CORNER_LAST);
		end
	endfunction

	function automatic sprite_t random_sprite();
		sprite_t sp;
		sp = SP_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 3))
			0: begin
				// keep corners in range most of the time
				sp.cx = CB'($urandom_range(0, 16000) - 8000);
				sp.cy = CB'($urandom_range(0, 16000) - 8000);
				sp.width = 16'($urandom_range(0, 4000));
				sp.height = 16'($urandom_range(0, 4000));
			end
			1: begin
				sp.div_u = 9'($urandom_range(1, 256));
				sp.div_v = 9'($urandom_range(1, 256));
				sp.pat_u = 8'($urandom_range(0, sp.div_u - 1));
				sp.pat_v = 8'($urandom_range(0, sp.div_v - 1));
			end
			default: ;
		endcase
		return sp;
	endfunction

	task automatic send_sprite(input sprite_t sp, input bit has_exp, input corner_t c0);
		corner_t q[4];
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		predict_corners(sp, q);
		if (has_exp) begin
			if (q[0].x !== c0.x)
				report_mismatch("directed corner_x", longint'($signed(q[0].x)),
					longint'($signed(c0.x)));
			if (q[0].y !== c0.y)
				report_mismatch("directed corner_y", longint'($signed(q[0].y)),
					longint'($signed(c0.y)));
			if (q[0].u !== c0.u) report_mismatch("directed tex_u", longint'(q[0].u), longint'(c0.u));
			if (q[0].v !== c0.v) report_mismatch("directed tex_v", longint'(q[0].v), longint'(c0.v));
			if (q[0].colour !== c0.colour)
				report_mismatch("directed colour", longint'(q[0].colour), longint'(c0.colour));
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(sp);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		for (int k = 0; k < 4; k++) pending_corners.push_back(q[k]);
	endtask

	// receive side: random stall bursts, check each word
	initial begin
		corner_t got, want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[CB-1:0];
				got.y = m_tdata[2*CB-1:CB];
				got.u = m_tdata[2*CB+15:2*CB];
				got.v = m_tdata[2*CB+31:2*CB+16];
				got.colour = m_tdata[2*CB+63:2*CB+32];
				got.index = m_tuser;
				got.last = m_tlast;
				if (pending_corners.size() == 0) begin
					report_mismatch("unexpected corner word", longint'(got.index), -64'sd1);
				end else begin
					want = pending_corners.pop_front();
					if (got.index !== want.index)
						report_mismatch("corner_index", longint'(got.index), longint'(want.index));
					if (got.x !== want.x)
						report_mismatch("corner_x", longint'($signed(got.x)),
							longint'($signed(want.x)));
					if (got.y !== want.y)
						report_mismatch("corner_y", longint'($signed(got.y)),
							longint'($signed(want.y)));
					if (got.u !== want.u) report_mismatch("tex_u", longint'(got.u), longint'(want.u));
					if (got.v !== want.v) report_mismatch("tex_v", longint'(got.v), longint'(want.v));
					if (got.colour !== want.colour)
						report_mismatch("colour", longint'(got.colour), longint'(want.colour));
					if (got.last !== want.last)
						report_mismatch("last_corner", longint'(got.last), longint'(want.last));
				end
			end
			if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("rotated_quad_vertex_generator_unit_test: errors");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		corner_t none;
		int n;
		none = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero size and no rotation: all corners at the centre
		rw.sp = '{colour: 32'hFF00FF00, div_v: 9'd1, div_u: 9'd1, pat_v: 8'd0, pat_u: 8'd0,
			height: 16'd0, width: 16'd0, rotation: 16'd0, cy: 16'sd100, cx: -16'sd50};
		rw.has_exp = 1;
		rw.c0 = '{index: 2'd0, last: 1'b0, colour: 32'hFF00FF00, v: 16'd0, u: 16'd0,
			y: 16'sd100, x: -16'sd50};
		rows.push_back(rw);
		// pattern beyond divisions saturates texture
		rw.sp.pat_u = 8'd255; rw.sp.pat_v = 8'd255; rw.sp.div_u = 9'd2; rw.sp.div_v = 9'd0;
		rw.sp.cx = 16'sh7FFF; rw.sp.cy = 16'sh8000; rw.sp.colour = 32'hFFFFFFFF;
		rw.c0 = '{index: 2'd0, last: 1'b0, colour: 32'hFFFFFFFF, v: 16'hFFFF, u: 16'hFFFF,
			y: 16'sh8000, x: 16'sh7FFF};
		rows.push_back(rw);
		rw.has_exp = 0;
		rw.c0 = none;
		// extremes of every field, divisions above 256, both saturation ends
		rw.sp = '{colour: 32'h0, div_v: 9'd511, div_u: 9'd257, pat_v: 8'd255, pat_u: 8'd0,
			height: 16'hFFFF, width: 16'hFFFF, rotation: 16'h0000, cy: 16'sh7FFF, cx: 16'sh8000};
		rows.push_back(rw);
		for (int a = 0; a < 16; a++) begin
			rw.sp.rotation = 16'(a * 16'h1000 + ((a & 1) ? 16'h0FFF : 16'h0));
			rw.sp.width = (a & 2) ? 16'hFFFF : 16'd320;
			rw.sp.height = (a & 4) ? 16'hFFFF : 16'd160;
			rw.sp.cx = (a & 8) ? 16'sh7FFF : 16'sd0;
			rw.sp.cy = (a & 8) ? 16'sh8000 : 16'sd0;
			rw.sp.div_u = 9'd256; rw.sp.div_v = 9'd3;
			rw.sp.pat_u = 8'(a * 17); rw.sp.pat_v = 8'(a % 3);
			rw.sp.colour = {a[7:0], 24'h5A5A5A};
			rows.push_back(rw);
		end
		rw.sp.rotation = 16'hFFFF;
		rows.push_back(rw);
		rw.sp.rotation = 16'h8000;
		rows.push_back(rw);

		foreach (rows[i]) send_sprite(rows[i].sp, rows[i].has_exp, rows[i].c0);
		for (n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 60) quiet_phase = 1;
			send_sprite(random_sprite(), 0, none);
		end
		s_tvalid <= 1'b0;
		while (pending_corners.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("rotated_quad_vertex_generator_unit_test: clean");
		end else begin
			$display("rotated_quad_vertex_generator_unit_test: errors");
		end
		$finish;
	end

endmodule
